// ----- hw/rtl/gpred_pkg.sv -----
// Shared types and constants for the geometric predicate unit.
// Holds the operation codes, field widths and pipeline depth; no dependencies.
`default_nettype none

package gpred_pkg;

   // Width of one coordinate field on the request channel.
   localparam int FIELD_W = 16;

   // Width of the operation code field.
   localparam int OP_W = 2;

   // Number of register stages from request to result.
   localparam int PIPE_STAGES = 6;

   // Packed stream widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 8;

   // Predicate selected by a request.
   typedef enum logic [OP_W-1:0] {
      OP_ON_LINE   = 2'd0,
      OP_CCW       = 2'd1,
      OP_RIGHT_OF  = 2'd2,
      OP_INCIRCLE  = 2'd3
   } op_type;

endpackage

`default_nettype wire

// ----- hw/rtl/gpred_datapath.sv -----
// Six-stage arithmetic datapath of the geometric predicate unit.
// Depends on gpred_pkg; each stage loads when its enable from the top level is high.
`default_nettype none

module gpred_datapath
   import gpred_pkg::*;
#(
   parameter int COORD_BITS = 16
)
(
   input  wire logic                        clock,
   input  wire logic [PIPE_STAGES-1:0]      stage_en,
   input  wire op_type                      operation,
   input  wire logic signed [FIELD_W-1:0]   pa_x,
   input  wire logic signed [FIELD_W-1:0]   pa_y,
   input  wire logic signed [FIELD_W-1:0]   pb_x,
   input  wire logic signed [FIELD_W-1:0]   pb_y,
   input  wire logic signed [FIELD_W-1:0]   pc_x,
   input  wire logic signed [FIELD_W-1:0]   pc_y,
   input  wire logic signed [FIELD_W-1:0]   pd_x,
   input  wire logic signed [FIELD_W-1:0]   pd_y,
   output logic                             verdict
);

   // Coordinate, difference, product, minor and partial product widths.
   localparam int CW = COORD_BITS;
   localparam int DW = CW + 1;
   localparam int SW = 2 * DW;
   localparam int MW = SW + 1;
   localparam int HW = (MW + 1) / 2;
   localparam int PW = 2 * HW + 2;
   localparam int TW = 2 * MW;
   localparam int AW = TW + 2;

   // Take the low COORD_BITS of a field as two's complement; the field bits
   // themselves are raw, so they are zero-extended first.
   function automatic logic signed [CW-1:0] coord(input logic signed [FIELD_W-1:0] f);
      logic signed [31:0] w;
      w = 32'($unsigned(f));
      return w[CW-1:0];
   endfunction

   function automatic logic signed [DW-1:0] diff(input logic signed [CW-1:0] p,
                                                 input logic signed [CW-1:0] q);
      return DW'(p) - DW'(q);
   endfunction

   // Low half of a minor-width value, as a nonnegative signed number.
   function automatic logic signed [HW:0] half_lo(input logic signed [MW-1:0] x);
      return $signed({1'b0, x[HW-1:0]});
   endfunction

   // High half of a minor-width value, keeping its sign.
   function automatic logic signed [HW:0] half_hi(input logic signed [MW-1:0] x);
      return (HW+1)'(x >>> HW);
   endfunction

   logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;

   // Stage 1: coordinate differences.
   logic signed [DW-1:0] id_in [6];
   logic signed [DW-1:0] od_in [4];
   logic signed [DW-1:0] id1_ff [6];
   logic signed [DW-1:0] od1_ff [4];
   op_type               op1_ff;

   // Stage 2: squares, cross products and the two orientation products.
   logic signed [SW-1:0] sq2_ff [6];
   logic signed [SW-1:0] cr2_ff [6];
   logic signed [SW-1:0] p2_ff, q2_ff;
   op_type               op2_ff;

   // Stage 3: lifted lengths, 2x2 minors and the orientation verdict.
   logic signed [MW-1:0] len3_ff [3];
   logic signed [MW-1:0] min3_ff [3];
   logic                 ori3_ff;
   op_type               op3_ff;

   // Stage 4: four partial products per incircle term.
   logic signed [PW-1:0] pp_in  [3][4];
   logic signed [PW-1:0] pp4_ff [3][4];
   logic                 ori4_ff;
   op_type               op4_ff;

   // Stage 5: assembled incircle terms.
   logic signed [TW-1:0] term_in  [3];
   logic signed [TW-1:0] term5_ff [3];
   logic                 ori5_ff;
   op_type               op5_ff;

   // Stage 6: determinant sign and final selection.
   logic signed [AW-1:0] det_in;
   logic                 verdict_in;
   logic                 verdict_ff;

   assign ax = coord(pa_x);
   assign ay = coord(pa_y);
   assign bx = coord(pb_x);
   assign by = coord(pb_y);
   assign cx = coord(pc_x);
   assign cy = coord(pc_y);
   assign dx = coord(pd_x);
   assign dy = coord(pd_y);

   // Differences relative to d for incircle; factor pairs for the orientation tests.
   always_comb begin
      id_in[0] = diff(ax, dx);
      id_in[1] = diff(ay, dy);
      id_in[2] = diff(bx, dx);
      id_in[3] = diff(by, dy);
      id_in[4] = diff(cx, dx);
      id_in[5] = diff(cy, dy);
      case (operation)
         OP_ON_LINE: begin
            od_in[0] = diff(cx, ax);
            od_in[1] = diff(cy, by);
            od_in[2] = diff(cy, ay);
            od_in[3] = diff(cx, bx);
         end
         OP_RIGHT_OF: begin
            od_in[0] = diff(cx, bx);
            od_in[1] = diff(by, ay);
            od_in[2] = diff(cy, by);
            od_in[3] = diff(bx, ax);
         end
         default: begin
            od_in[0] = diff(ax, bx);
            od_in[1] = diff(by, cy);
            od_in[2] = diff(ay, by);
            od_in[3] = diff(bx, cx);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         id1_ff <= id_in;
         od1_ff <= od_in;
         op1_ff <= operation;
      end
   end

   // Differences are ordered adx, ady, bdx, bdy, cdx, cdy.
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         for (int i = 0; i < 6; i++) begin
            sq2_ff[i] <= SW'(id1_ff[i]) * SW'(id1_ff[i]);
         end
         cr2_ff[0] <= SW'(id1_ff[2]) * SW'(id1_ff[5]);
         cr2_ff[1] <= SW'(id1_ff[4]) * SW'(id1_ff[3]);
         cr2_ff[2] <= SW'(id1_ff[4]) * SW'(id1_ff[1]);
         cr2_ff[3] <= SW'(id1_ff[0]) * SW'(id1_ff[5]);
         cr2_ff[4] <= SW'(id1_ff[0]) * SW'(id1_ff[3]);
         cr2_ff[5] <= SW'(id1_ff[2]) * SW'(id1_ff[1]);
         p2_ff     <= SW'(od1_ff[0]) * SW'(od1_ff[1]);
         q2_ff     <= SW'(od1_ff[2]) * SW'(od1_ff[3]);
         op2_ff    <= op1_ff;
      end
   end

   // On-line is an equality test; the other orientation tests are strict.
   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         for (int k = 0; k < 3; k++) begin
            len3_ff[k] <= MW'(sq2_ff[2*k]) + MW'(sq2_ff[2*k+1]);
            min3_ff[k] <= MW'(cr2_ff[2*k]) - MW'(cr2_ff[2*k+1]);
         end
         ori3_ff <= (op2_ff == OP_ON_LINE) ? (p2_ff == q2_ff) : (p2_ff > q2_ff);
         op3_ff  <= op2_ff;
      end
   end

   // Each term is length times minor, split into halves to keep multipliers narrow.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pp_in[k][0] = PW'(half_lo(len3_ff[k])) * PW'(half_lo(min3_ff[k]));
         pp_in[k][1] = PW'(half_lo(len3_ff[k])) * PW'(half_hi(min3_ff[k]));
         pp_in[k][2] = PW'(half_hi(len3_ff[k])) * PW'(half_lo(min3_ff[k]));
         pp_in[k][3] = PW'(half_hi(len3_ff[k])) * PW'(half_hi(min3_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         pp4_ff  <= pp_in;
         ori4_ff <= ori3_ff;
         op4_ff  <= op3_ff;
      end
   end

   // Reassemble each term from its shifted partial products.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         term_in[k] = TW'(pp4_ff[k][0])
                    + ((TW'(pp4_ff[k][1]) + TW'(pp4_ff[k][2])) <<< HW)
                    + (TW'(pp4_ff[k][3]) <<< (2 * HW));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         term5_ff <= term_in;
         ori5_ff  <= ori4_ff;
         op5_ff   <= op4_ff;
      end
   end

   // A positive translated determinant means d lies strictly inside the circle when a, b, c are counter-clockwise.
   always_comb begin
      det_in     = AW'(term5_ff[0]) + AW'(term5_ff[1]) + AW'(term5_ff[2]);
      verdict_in = (op5_ff == OP_INCIRCLE) ? (det_in > AW'(0)) : ori5_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         verdict_ff <= verdict_in;
      end
   end

   assign verdict = verdict_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/geometric_predicate_unit_core.sv -----
// Geometric predicate unit: orientation and incircle tests for 2D triangulation.
// Uses gpred_pkg and gpred_datapath; this file holds the stream handshake and valid bits.
//
// Usage:
//   Each request on req_ carries an operation code and up to four points a, b, c, d.
//   The unit answers with one response on rsp_ whose tdata[0] is the verdict:
//   on-line, counter-clockwise, right-of, or d strictly inside the circle through a, b, c.
//   All arithmetic is exact; coordinates are the low COORD_BITS of each field.
//   Each accepted request passes through the six registered stages in order; its response
//   is valid once it reaches the last stage. Throughput: one request per cycle while
//   rsp_tready is high; the six stages each hold one request, and the multiplier
//   stages (squares and products, then split partial products) set the depth.
//   Backpressure: each stage advances when it is empty or the stage after it advances,
//   so empty stages fill even while rsp_tready is low; req_tready falls only when
//   every stage holds a request and rsp_tready is low. Nothing is dropped or repeated.
//   Reset: synchronous, active high; clears all valid bits, no response is pending.
//   The unit has no state between requests.
`default_nettype none

module geometric_predicate_unit_core
   import gpred_pkg::*;
#(
   parameter int COORD_BITS = 16
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // operation[1:0], pa_x[17:2], pa_y[33:18], pb_x[49:34], pb_y[65:50],
   // pc_x[81:66], pc_y[97:82], pd_x[113:98], pd_y[129:114], zeros above
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // verdict[0], zeros above
   output logic [RSP_DATA_W-1:0]        rsp_tdata
);

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES-1:0] stage_en;
   logic                   verdict;

   // A stage loads when it is empty or its content moves on.
   always_comb begin
      stage_en[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || rsp_tready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   // Valid bits follow the data through each enabled stage.
   always_comb begin
      valid_in = valid_ff;
      if (stage_en[0]) begin
         valid_in[0] = req_tvalid;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
         if (stage_en[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Arithmetic stages.
   gpred_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .stage_en  (stage_en),
      .operation (op_type'(req_tdata[OP_W-1:0])),
      .pa_x      (req_tdata[OP_W + 0*FIELD_W +: FIELD_W]),
      .pa_y      (req_tdata[OP_W + 1*FIELD_W +: FIELD_W]),
      .pb_x      (req_tdata[OP_W + 2*FIELD_W +: FIELD_W]),
      .pb_y      (req_tdata[OP_W + 3*FIELD_W +: FIELD_W]),
      .pc_x      (req_tdata[OP_W + 4*FIELD_W +: FIELD_W]),
      .pc_y      (req_tdata[OP_W + 5*FIELD_W +: FIELD_W]),
      .pd_x      (req_tdata[OP_W + 6*FIELD_W +: FIELD_W]),
      .pd_y      (req_tdata[OP_W + 7*FIELD_W +: FIELD_W]),
      .verdict   (verdict)
   );

   // Stream outputs.
   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[PIPE_STAGES-1];
   assign rsp_tdata  = {(RSP_DATA_W-1)'(0), verdict};

`ifndef SYNTHESIS
   // A full pipeline with a stalled output must not take another request.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_tready) |-> !req_tready)
      else $error("request taken while the pipeline is full and stalled");

   // Reset empties every stage.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("valid bits not cleared by reset");

   // A stage that holds a request and is not enabled keeps it.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((valid_ff & $past(valid_ff & ~stage_en)) == $past(valid_ff & ~stage_en)))
      else $error("stalled stage lost its request");

   // An accepted request occupies the first stage on the next cycle.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted request did not enter the pipeline");
`endif

endmodule

`default_nettype wire
